// ----- hw/rtl/ccd_pkg.sv -----
// Shared types and constants for the cloud-in-cell charge deposit block.
package ccd_pkg;

  localparam int ADDR_W_MAX  = 26;
  localparam int WGT_W       = 18;
  localparam int CELL_W      = 48;
  localparam int INC_W       = 54;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic KIND_DEPOSIT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE_3D       = 3'd0,
    REG_ORIGIN_X      = 3'd1,
    REG_ORIGIN_Y      = 3'd2,
    REG_ORIGIN_Z      = 3'd3,
    REG_INV_SPACING_X = 3'd4,
    REG_INV_SPACING_Y = 3'd5,
    REG_INV_SPACING_Z = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] charge;
    logic [4:0]         cell_x;
    logic [4:0]         cell_y;
    logic [5:0]         cell_z;
  } item_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_value;
    logic                     out_of_bounds;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic               mode_3d;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [31:0]        inv_spacing_x;
    logic [31:0]        inv_spacing_y;
    logic [31:0]        inv_spacing_z;
  } cfg_t;

  typedef struct packed {
    logic                    kind;
    logic                    mode_3d;
    logic                    oob;
    logic                    inb;
    logic [ADDR_W_MAX-1:0]   addr;
    logic signed [31:0]      charge;
    logic signed [WGT_W-1:0] wx0;
    logic signed [WGT_W-1:0] wx1;
    logic signed [WGT_W-1:0] wy0;
    logic signed [WGT_W-1:0] wy1;
    logic signed [WGT_W-1:0] wz0;
    logic signed [WGT_W-1:0] wz1;
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_READ
  } back_state_e;

endpackage

// ----- hw/rtl/ccd_stream_if.sv -----
// Valid/ready stream interface carrying one payload per transfer.
interface ccd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/ccd_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ccd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hw/rtl/ccd_queue.sv -----
// Short command queue between the front and back ends.
module ccd_queue import ccd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_o
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign push_ready_o = count_q != CW'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_o        = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_i;
    end
  end
endmodule

// ----- hw/rtl/ccd_front.sv -----
// Front end: accept items, locate the particle, form weights and cell address.
module ccd_front import ccd_pkg::*; #(
  parameter int GRID_X      = 32,
  parameter int GRID_Y      = 32,
  parameter int GRID_Z      = 64,
  parameter int GHOST_CELLS = 1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  clearing_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  cmd_valid_o,
  input  logic  cmd_ready_i,
  output cmd_t  cmd_o
);
  localparam int XY = GRID_X * GRID_Y;
  localparam int N  = XY * GRID_Z;
  localparam int AW = $clog2(N);
  localparam int GRID [3] = '{GRID_X, GRID_Y, GRID_Z};

  logic [3:0]         stage_q;
  item_t              item_q;
  logic signed [32:0] d_q [3];
  logic signed [32:0] d_d [3];
  logic signed [65:0] prod_q [3];
  logic signed [65:0] prod_d [3];
  cmd_t               cmd_q, cmd_d;

  logic signed [31:0]      pos [3];
  logic signed [31:0]      org [3];
  logic [31:0]             inv [3];
  logic signed [50:0]      loc [3];
  logic signed [35:0]      ix [3];
  logic [35:0]             ixm [3];
  logic                    adj [3];
  logic signed [WGT_W-1:0] up [3];
  logic signed [WGT_W-1:0] wlo [3];
  logic                    oob;
  logic                    inb;
  logic [AW-1:0]           base, raddr;
  logic                    accept;

  assign in_ready_o  = (stage_q == '0) && !clearing_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = stage_q[3];
  assign cmd_o       = cmd_q;

  assign pos[0] = item_q.pos_x;
  assign pos[1] = item_q.pos_y;
  assign pos[2] = item_q.pos_z;
  assign org[0] = cfg_i.origin_x;
  assign org[1] = cfg_i.origin_y;
  assign org[2] = cfg_i.origin_z;
  assign inv[0] = cfg_i.inv_spacing_x;
  assign inv[1] = cfg_i.inv_spacing_y;
  assign inv[2] = cfg_i.inv_spacing_z;

  always_comb begin
    oob = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      d_d[ax]    = $signed({pos[ax][31], pos[ax]}) - $signed({org[ax][31], org[ax]});
      prod_d[ax] = d_q[ax] * $signed({1'b0, inv[ax]});
      loc[ax]    = $signed({prod_q[ax][65], prod_q[ax][65:16]}) + 51'sd32768;
      adj[ax]    = loc[ax][50] && (loc[ax][15:0] != '0);
      ix[ax]     = $signed({loc[ax][50], loc[ax][50:16]}) + $signed({35'd0, adj[ax]})
                   + 36'(GHOST_CELLS);
      ixm[ax]    = ix[ax] - 36'sd1;
      up[ax]     = adj[ax] ? $signed({2'b11, loc[ax][15:0]}) : $signed({2'b00, loc[ax][15:0]});
      wlo[ax]    = 18'sd65536 - up[ax];
      if (ix[ax] < 36'sd1 || ix[ax] > 36'(GRID[ax] - 1)) begin
        oob = 1'b1;
      end
    end
    base  = AW'(ixm[0]) + AW'(GRID_X) * AW'(ixm[1]) + AW'(XY) * AW'(ixm[2]);
    inb   = (32'(item_q.cell_x) < GRID_X) && (32'(item_q.cell_y) < GRID_Y)
            && (32'(item_q.cell_z) < GRID_Z);
    raddr = AW'(item_q.cell_x) + AW'(GRID_X) * AW'(item_q.cell_y)
            + AW'(XY) * AW'(item_q.cell_z);

    cmd_d         = '0;
    cmd_d.kind    = item_q.kind;
    cmd_d.mode_3d = cfg_i.mode_3d;
    cmd_d.oob     = (item_q.kind == KIND_DEPOSIT) && oob;
    cmd_d.inb     = inb;
    cmd_d.addr    = ADDR_W_MAX'((item_q.kind == KIND_READ) ? raddr : base);
    cmd_d.charge  = item_q.charge;
    cmd_d.wx0     = wlo[0];
    cmd_d.wx1     = up[0];
    cmd_d.wy0     = wlo[1];
    cmd_d.wy1     = up[1];
    cmd_d.wz0     = wlo[2];
    cmd_d.wz1     = up[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q[0] <= accept;
      stage_q[1] <= stage_q[0];
      stage_q[2] <= stage_q[1];
      stage_q[3] <= stage_q[2] || (stage_q[3] && !cmd_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (stage_q[0]) begin
      d_q <= d_d;
    end
    if (stage_q[1]) begin
      prod_q <= prod_d;
    end
    if (stage_q[2]) begin
      cmd_q <= cmd_d;
    end
  end
endmodule

// ----- hw/rtl/ccd_back.sv -----
// Back end: clear the grid, run cell read-modify-write updates and read-and-clear reads.
module ccd_back import ccd_pkg::*; #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  output logic                                 cmd_ready_o,
  input  cmd_t                                 cmd_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output result_t                              out_o,
  output logic                                 clearing_o,
  output logic                                 mem_we_o,
  output logic [$clog2(GRID_X*GRID_Y*GRID_Z)-1:0] mem_waddr_o,
  output logic [CELL_W-1:0]                    mem_wdata_o,
  output logic [$clog2(GRID_X*GRID_Y*GRID_Z)-1:0] mem_raddr_o,
  input  logic [CELL_W-1:0]                    mem_rdata_i
);
  localparam int XY = GRID_X * GRID_Y;
  localparam int N  = XY * GRID_Z;
  localparam int AW = $clog2(N);

  back_state_e state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [2:0]    k_q;
  cmd_t          cmd_q;
  logic          sat_q;
  logic          out_valid_q;
  result_t       out_q, res_d;
  logic          load, issue;

  logic               s1_v_q, s2_v_q, s3_v_q;
  logic signed [35:0] p1_q;
  logic signed [37:0] p2_q;
  logic signed [INC_W-1:0] inc_q;
  logic               s1_c_q;
  logic [AW-1:0]      s1_addr_q, s2_addr_q, s3_addr_q;

  logic signed [WGT_W-1:0] wxs, wys, wzs;
  logic signed [19:0]      w2;
  logic signed [21:0]      w3;
  logic [AW-1:0]           cell_addr;
  logic signed [54:0]      sum;
  logic                    clip;
  logic [CELL_W-1:0]       sat_val;
  logic                    pipe_empty;

  assign clearing_o  = state_q == B_CLEAR;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign pipe_empty  = !s1_v_q && !s2_v_q && !s3_v_q;

  assign wxs       = k_q[0] ? cmd_q.wx1 : cmd_q.wx0;
  assign wys       = k_q[1] ? cmd_q.wy1 : cmd_q.wy0;
  assign wzs       = s1_c_q ? cmd_q.wz1 : cmd_q.wz0;
  assign w2        = p1_q[35:16];
  assign w3        = p2_q[37:16];
  assign cell_addr = cmd_q.addr[AW-1:0] + AW'(k_q[0])
                     + (k_q[1] ? AW'(GRID_X) : '0) + (k_q[2] ? AW'(XY) : '0);
  assign sum       = $signed({{7{mem_rdata_i[CELL_W-1]}}, mem_rdata_i})
                     + $signed({inc_q[INC_W-1], inc_q});
  assign clip      = !((&sum[54:47]) || !(|sum[54:47]));
  assign sat_val   = clip ? (sum[54] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : sum[47:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: begin
        if (clr_q == AW'(N - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          if (cmd_i.kind == KIND_READ) begin
            state_d = B_READ;
          end else if (!cmd_i.oob) begin
            state_d = B_RUN;
          end
        end
      end
      B_RUN: begin
        if (k_q == 3'd7) begin
          state_d = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (pipe_empty) begin
          state_d = B_IDLE;
        end
      end
      B_READ: begin
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    issue       = 1'b0;
    load        = 1'b0;
    res_d       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = s3_addr_q;
    mem_wdata_o = sat_val;
    mem_raddr_o = s2_addr_q;
    unique case (state_q)
      B_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
      end
      B_IDLE: begin
        mem_raddr_o = cmd_i.addr[AW-1:0];
        if (cmd_valid_i && !out_valid_q) begin
          cmd_ready_o = 1'b1;
          if (cmd_i.kind == KIND_DEPOSIT && cmd_i.oob) begin
            load                = 1'b1;
            res_d.out_of_bounds = 1'b1;
          end
        end
      end
      B_RUN: begin
        issue = 1'b1;
      end
      B_DRAIN: begin
        if (pipe_empty) begin
          load            = 1'b1;
          res_d.saturated = sat_q;
        end
      end
      B_READ: begin
        load             = 1'b1;
        res_d.cell_value = cmd_q.inb ? $signed(mem_rdata_i) : '0;
        mem_we_o         = cmd_q.inb;
        mem_waddr_o      = cmd_q.addr[AW-1:0];
        mem_wdata_o      = '0;
      end
      default: begin
        load = 1'b0;
      end
    endcase
    if (s3_v_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = s3_addr_q;
      mem_wdata_o = sat_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_ready_o) begin
        k_q   <= cmd_i.mode_3d ? 3'd0 : 3'd4;
        sat_q <= 1'b0;
      end else if (issue) begin
        k_q <= k_q + 1'b1;
      end
      if (s3_v_q && clip) begin
        sat_q <= 1'b1;
      end
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o) begin
      cmd_q <= cmd_i;
    end
    if (issue) begin
      p1_q      <= wxs * wys;
      s1_c_q    <= k_q[2];
      s1_addr_q <= cell_addr;
    end
    if (s1_v_q) begin
      p2_q      <= cmd_q.mode_3d ? 38'(w2 * wzs) : $signed({{2{w2[19]}}, w2, 16'd0});
      s2_addr_q <= s1_addr_q;
    end
    if (s2_v_q) begin
      inc_q     <= w3 * cmd_q.charge;
      s3_addr_q <= s2_addr_q;
    end
    if (load) begin
      out_q <= res_d;
    end
  end
endmodule

// ----- hw/rtl/cloud_in_cell_charge_deposit.sv -----
// Top level: configuration registers, front end, command queue, back end and grid RAM.
// The back end's read-modify-write pass over one grid RAM port (one cell per cycle) sets the
//   deposit rate, and the four-stage front end, which takes no new item until its last command
//   has gone into the queue, sets the read rate.
// Reset: configuration takes its defaults and a sweep writes zero to all
//   GRID_X*GRID_Y*GRID_Z cells, one per cycle, with item ready held low meanwhile.
module cloud_in_cell_charge_deposit import ccd_pkg::*; #(
  parameter int GRID_X      = 32,
  parameter int GRID_Y      = 32,
  parameter int GRID_Z      = 64,
  parameter int GHOST_CELLS = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ccd_stream_if.sink            item_i,
  ccd_stream_if.source          result_o
);
  localparam int N  = GRID_X * GRID_Y * GRID_Z;
  localparam int AW = $clog2(N);

  cfg_t              cfg_q;
  logic              clearing;
  logic              cmd_valid, cmd_ready, q_valid, q_ready;
  cmd_t              cmd, q_cmd;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_3d       <= 1'b1;
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.origin_z      <= '0;
      cfg_q.inv_spacing_x <= 32'd65536;
      cfg_q.inv_spacing_y <= 32'd65536;
      cfg_q.inv_spacing_z <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE_3D:       cfg_q.mode_3d       <= cfg_wdata_i[0];
        REG_ORIGIN_X:      cfg_q.origin_x      <= cfg_wdata_i;
        REG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_wdata_i;
        REG_ORIGIN_Z:      cfg_q.origin_z      <= cfg_wdata_i;
        REG_INV_SPACING_X: cfg_q.inv_spacing_x <= cfg_wdata_i;
        REG_INV_SPACING_Y: cfg_q.inv_spacing_y <= cfg_wdata_i;
        REG_INV_SPACING_Z: cfg_q.inv_spacing_z <= cfg_wdata_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  ccd_front #(
    .GRID_X      (GRID_X),
    .GRID_Y      (GRID_Y),
    .GRID_Z      (GRID_Z),
    .GHOST_CELLS (GHOST_CELLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clearing_i  (clearing),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .in_item_i   (item_i.payload),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  ccd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_i       (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_o        (q_cmd)
  );

  ccd_back #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_o       (result_o.payload),
    .clearing_o  (clearing),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ccd_ram #(
    .WIDTH (CELL_W),
    .DEPTH (N)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );
endmodule

// ----- tb/sv/cloud_in_cell_charge_deposit_test.sv -----
// Self-checking testbench for the cloud-in-cell charge deposit block: stimulus, predictor, checker.
module cloud_in_cell_charge_deposit_test;
  import ccd_pkg::*;

  localparam int GX = 32;
  localparam int GY = 32;
  localparam int GZ = 64;
  localparam int GHOST = 1;
  localparam longint CELL_HI = 64'sd140737488355327;
  localparam longint CELL_LO = -64'sd140737488355328;
  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 120;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ccd_stream_if #(.payload_t(item_t)) item_if ();
  ccd_stream_if #(.payload_t(result_t)) result_if ();

  cloud_in_cell_charge_deposit #(
    .GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ), .GHOST_CELLS(GHOST)
  ) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .item_i(item_if), .result_o(result_if)
  );

  cfg_t model_cfg;
  longint charge_grid[int];
  int touched_q[$];
  item_t pend_q[$];
  result_t expected_q[$];
  int errors;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void locate_axis(input logic signed [31:0] pos, input logic signed [31:0] org,
                                      input logic [31:0] inv, output longint idx,
                                      output longint up);
    longint d;
    logic [63:0] m;
    logic [63:0] p;
    longint q;
    longint loc;
    longint i;
    d = longint'(pos) - longint'(org);
    m = (d < 0) ? -d : d;
    p = m * {32'b0, inv};
    q = (d < 0) ? -longint'((p + 64'hFFFF) >> 16) : longint'(p >> 16);
    loc = q + 32768;
    i = (loc >= 0) ? (loc >>> 16) : -((-loc) >>> 16);
    up = loc - i * 65536;
    idx = i + GHOST;
  endfunction

  function automatic result_t deposit_or_read(input item_t it);
    result_t r;
    longint ix, iy, iz, ux, uy, uz, w, s;
    longint wx[2], wy[2], wz[2];
    int addr;
    r = '0;
    if (it.kind == KIND_READ) begin
      addr = int'(it.cell_x) + GX * (int'(it.cell_y) + GY * int'(it.cell_z));
      if (charge_grid.exists(addr)) begin
        r.cell_value = charge_grid[addr][CELL_W-1:0];
        charge_grid.delete(addr);
      end
      return r;
    end
    locate_axis(it.pos_x, model_cfg.origin_x, model_cfg.inv_spacing_x, ix, ux);
    locate_axis(it.pos_y, model_cfg.origin_y, model_cfg.inv_spacing_y, iy, uy);
    locate_axis(it.pos_z, model_cfg.origin_z, model_cfg.inv_spacing_z, iz, uz);
    if (ix <= 0 || ix >= GX || iy <= 0 || iy >= GY || iz <= 0 || iz >= GZ) begin
      r.out_of_bounds = 1'b1;
      return r;
    end
    wx[0] = 65536 - ux; wx[1] = ux;
    wy[0] = 65536 - uy; wy[1] = uy;
    wz[0] = 65536 - uz; wz[1] = uz;
    for (int c = 0; c < 2; c++) begin
      if (!model_cfg.mode_3d && c == 0) continue;
      for (int b = 0; b < 2; b++) begin
        for (int a = 0; a < 2; a++) begin
          w = (wx[a] * wy[b]) >>> 16;
          if (model_cfg.mode_3d) w = (w * wz[c]) >>> 16;
          addr = int'(ix - 1 + a) + GX * (int'(iy - 1 + b) + GY * int'(iz - 1 + c));
          s = (charge_grid.exists(addr) ? charge_grid[addr] : 0) + w * longint'(it.charge);
          if (s > CELL_HI) begin s = CELL_HI; r.saturated = 1'b1; end
          if (s < CELL_LO) begin s = CELL_LO; r.saturated = 1'b1; end
          charge_grid[addr] = s;
          if (touched_q.size() < 4096) touched_q = {touched_q, addr};
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic queue_item(input item_t it);
    pend_q = {pend_q, it};
  endtask

  // Monitor: predict on item transfer, check on result transfer.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) expected_q = {expected_q, deposit_or_read(item_if.payload)};
      if (result_if.valid && result_if.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (result_if.payload.cell_value !== want.cell_value)
            report_mismatch("cell_value", longint'(result_if.payload.cell_value),
                            longint'(want.cell_value));
          if (result_if.payload.out_of_bounds !== want.out_of_bounds)
            report_mismatch("out_of_bounds", longint'(result_if.payload.out_of_bounds),
                            longint'(want.out_of_bounds));
          if (result_if.payload.saturated !== want.saturated)
            report_mismatch("saturated", longint'(result_if.payload.saturated),
                            longint'(want.saturated));
        end
      end
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[cloud_in_cell_charge_deposit] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Driver: bursts of items with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv;
    item_t np;
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      item_if.payload <= '0;
      burst_left <= 4;
      gap_left <= 0;
    end else if (!(item_if.valid && !item_if.ready)) begin
      nv = 1'b0;
      np = item_if.payload;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pend_q.size() > 0) begin
        np = pend_q.pop_front();
        nv = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      item_if.valid <= nv;
      item_if.payload <= np;
    end
  end

  // Receiver: stall pattern is chosen at random and changed by a free-running counter.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_mode <= 0;
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: result_if.ready <= 1'b1;
        1: result_if.ready <= 1'($urandom_range(0, 1));
        default: result_if.ready <= (stall_cnt % 4 == 0);
      endcase
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    case (idx)
      REG_MODE_3D: model_cfg.mode_3d = v[0];
      REG_ORIGIN_X: model_cfg.origin_x = v;
      REG_ORIGIN_Y: model_cfg.origin_y = v;
      REG_ORIGIN_Z: model_cfg.origin_z = v;
      REG_INV_SPACING_X: model_cfg.inv_spacing_x = v;
      REG_INV_SPACING_Y: model_cfg.inv_spacing_y = v;
      default: model_cfg.inv_spacing_z = v;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || item_if.valid || expected_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_phase(input logic m3, input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] oz, input logic [31:0] sx,
                           input logic [31:0] sy, input logic [31:0] sz);
    wait_idle();
    write_reg(REG_MODE_3D, {31'b0, m3});
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_SPACING_X, sx);
    write_reg(REG_INV_SPACING_Y, sy);
    write_reg(REG_INV_SPACING_Z, sz);
  endtask

  function automatic logic [31:0] pos_inside(input logic [31:0] org, input logic [31:0] inv,
                                             input int cells);
    longint span;
    if (inv == 0) return $urandom;
    span = (longint'(cells) <<< 32) / longint'(inv);
    if (span > 64'sh7FFFFFFF) span = 64'sh7FFFFFFF;
    return org + $urandom_range(0, int'(span));
  endfunction

  function automatic item_t make_deposit(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z, input logic [31:0] q);
    item_t it;
    it = '0;
    it.kind = KIND_DEPOSIT;
    it.pos_x = x; it.pos_y = y; it.pos_z = z; it.charge = q;
    it.cell_x = 5'($urandom); it.cell_y = 5'($urandom); it.cell_z = 6'($urandom);
    return it;
  endfunction

  function automatic item_t make_read(input int cx, input int cy, input int cz);
    item_t it;
    it = make_deposit($urandom, $urandom, $urandom, $urandom);
    it.kind = KIND_READ;
    it.cell_x = 5'(cx); it.cell_y = 5'(cy); it.cell_z = 6'(cz);
    return it;
  endfunction

  task automatic push_random(input int n);
    item_t it;
    int addr;
    logic [31:0] q;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          it = make_deposit($urandom, $urandom, $urandom, $urandom);
          it.kind = 1'($urandom);
        end
        1, 2, 3: begin
          if (touched_q.size() > 0 && $urandom_range(0, 3) != 0) begin
            addr = touched_q[$urandom_range(0, touched_q.size() - 1)];
            it = make_read(addr % GX, (addr / GX) % GY, addr / (GX * GY));
          end else begin
            it = make_read($urandom, $urandom, $urandom);
          end
        end
        default: begin
          q = ($urandom_range(0, 7) == 0) ? {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'h3FFFFFF0}
                                           : $urandom;
          it = make_deposit(pos_inside(model_cfg.origin_x, model_cfg.inv_spacing_x, GX - 2),
                            pos_inside(model_cfg.origin_y, model_cfg.inv_spacing_y, GY - 2),
                            pos_inside(model_cfg.origin_z, model_cfg.inv_spacing_z, GZ - 2), q);
        end
      endcase
      queue_item(it);
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_MODE_3D;
    cfg_wdata_i = '0;
    model_cfg = '{mode_3d: 1'b1, origin_x: 0, origin_y: 0, origin_z: 0,
                  inv_spacing_x: 32'h10000, inv_spacing_y: 32'h10000,
                  inv_spacing_z: 32'h10000};
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cell centers give a single full-weight cell; drive one such cell past each limit
    queue_item(make_deposit(32'h58000, 32'h58000, 32'h58000, 32'h7FFFFFFF));
    queue_item(make_deposit(32'h58000, 32'h58000, 32'h58000, 32'h7FFFFFFF));
    queue_item(make_read(5, 5, 5));
    queue_item(make_deposit(32'h98000, 32'h38000, 32'h3D8000, 32'h80000000));
    queue_item(make_deposit(32'h98000, 32'h38000, 32'h3D8000, 32'h80000000));
    queue_item(make_read(9, 3, 61));
    queue_item(make_deposit(32'h7FFFFFFF, 32'h10000, 32'h10000, 32'h10000));
    queue_item(make_deposit(32'h10000, 32'h80000000, 32'h10000, 32'h10000));
    queue_item(make_deposit(32'h10000, 32'h10000, 32'h80000000, 32'h10000));
    queue_item(make_deposit(32'hFFFFC000, 32'hFFFF4000, 32'h0, 32'h12345));
    queue_item(make_read(0, 0, 0));
    queue_item(make_read(0, 1, 0));
    queue_item(make_deposit(32'h1E6666, 32'h1E6666, 32'h3E6666, 32'hFFFF0000));
    queue_item(make_deposit(32'h1F0000, 32'h10000, 32'h10000, 32'h10000));
    queue_item(make_deposit(32'h10000, 32'h10000, 32'h3F0000, 32'h10000));
    queue_item(make_deposit(32'h24000, 32'h31000, 32'h47000, 32'h0));
    queue_item(make_read(31, 31, 63));
    queue_item(make_read(30, 30, 62));
    push_random(RANDOM_ITEMS);

    set_phase(1'b0, 32'hFFF80000, 32'hFFFF0000, 32'h00020000,
              32'h00020000, 32'h00018000, 32'h00010000);
    push_random(RANDOM_ITEMS);

    set_phase(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h0,
              32'h0, 32'hFFFFFFFF, 32'h00008000);
    push_random(RANDOM_ITEMS);

    set_phase(1'b0, 32'h00012345, 32'h0, 32'hFFFFFFFF,
              32'h0000C000, 32'h00010000, 32'h0);
    push_random(RANDOM_ITEMS);

    wait_idle();
    if (errors == 0) begin
      $display("[cloud_in_cell_charge_deposit] OK");
    end else begin
      $display("[cloud_in_cell_charge_deposit] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ccd_pkg.sv
hw/rtl/ccd_stream_if.sv
hw/rtl/ccd_ram.sv
hw/rtl/ccd_queue.sv
hw/rtl/ccd_front.sv
hw/rtl/ccd_back.sv
hw/rtl/cloud_in_cell_charge_deposit.sv
tb/sv/cloud_in_cell_charge_deposit_test.sv
